// ----- src/abrc_pkg.sv -----
// abrc_pkg: shared types, codes and timing constants for the alarm buzzer
// ramp controller. Used by every module under src; depends on nothing.
`default_nettype none

package abrc_pkg;

   // field widths
   localparam int TIME_W   = 16;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int DUTY_W   = 11;
   localparam int RAMPS_W  = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   // opcodes
   localparam logic OP_TICK       = 1'b0;
   localparam logic OP_SET_ENABLE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_HOURS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_MINUTES = 1'b1;

   // register reset values
   localparam logic [HOUR_W-1:0]   ALARM_HOURS_RESET   = 5'd10;
   localparam logic [MINUTE_W-1:0] ALARM_MINUTES_RESET = 6'd0;

   // ramp and timing constants
   localparam logic [RAMPS_W-1:0] RAMP_COUNT      = 4'd10;
   localparam logic [DUTY_W-1:0]  DUTY_FIRST      = 11'h2FF;
   localparam logic [DUTY_W-1:0]  DUTY_LIMIT      = 11'h400;
   localparam logic [DUTY_W-1:0]  DUTY_STEP       = 11'h001;
   localparam logic [TIME_W-1:0]  HALF_PERIOD_MS  = 16'd300;
   localparam logic [TIME_W-1:0]  OFF_HOLD_MS     = 16'd8000;
   localparam logic [TIME_W-1:0]  RESTART_HOLD_MS = 16'd1000;

   // one input word
   typedef struct packed {
      logic                opcode;
      logic [TIME_W-1:0]   now_millis;
      logic                switch_pressed;
      logic [HOUR_W-1:0]   rtc_hours;
      logic [MINUTE_W-1:0] rtc_minutes;
      logic                enable_value;
   } req_item_type;

   // one result word
   typedef struct packed {
      logic [DUTY_W-1:0] pwm_duty;
      logic              alarm_active;
      logic              alarm_armed;
   } rsp_item_type;

endpackage

`default_nettype wire

// ----- src/abrc_in_stage.sv -----
// abrc_in_stage: input register of the controller, holds one request word
// and its valid flag. Depends on abrc_pkg.
`default_nettype none

module abrc_in_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire abrc_pkg::req_item_type in_item,
   output logic                        in_stall,
   input  wire logic                   take,
   output logic                        valid_ff,
   output abrc_pkg::req_item_type      item_ff
);

   logic                   valid_in;
   logic                   accept;
   abrc_pkg::req_item_type item_in;

   // hold while the word cannot move on
   assign in_stall = valid_ff & ~take;
   assign accept   = in_valid & ~in_stall;
   assign valid_in = accept | (valid_ff & ~take);
   assign item_in  = accept ? in_item : item_ff;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

// ----- src/abrc_core.sv -----
// abrc_core: alarm registers and alarm state, with the one-pass update for
// a tick or a set-enable word. Depends on abrc_pkg.
`default_nettype none

module abrc_core (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_write_enable,
   input  wire logic [abrc_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [abrc_pkg::CSR_DATA_W-1:0]         csr_write_data,
   input  wire logic                                    fire,
   input  wire abrc_pkg::req_item_type                  item,
   output abrc_pkg::rsp_item_type                       result
);

   // alarm time registers
   logic [abrc_pkg::HOUR_W-1:0]   alarm_hours_ff;
   logic [abrc_pkg::MINUTE_W-1:0] alarm_minutes_ff;

   // alarm state
   logic                          armed_ff, armed_in;
   logic                          active_ff, active_in;
   logic                          beep_on_ff, beep_on_in;
   logic [abrc_pkg::DUTY_W-1:0]   ramp_duty_ff, ramp_duty_in;
   logic [abrc_pkg::RAMPS_W-1:0]  ramps_left_ff, ramps_left_in;
   logic [abrc_pkg::TIME_W-1:0]   toggle_start_ff, toggle_start_in;
   logic                          switch_held_ff, switch_held_in;
   logic [abrc_pkg::TIME_W-1:0]   switch_start_ff, switch_start_in;
   logic [abrc_pkg::DUTY_W-1:0]   loaded_duty_ff, loaded_duty_in;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_hours_ff   <= abrc_pkg::ALARM_HOURS_RESET;
         alarm_minutes_ff <= abrc_pkg::ALARM_MINUTES_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            abrc_pkg::CSR_ALARM_HOURS:
               alarm_hours_ff <= csr_write_data[abrc_pkg::HOUR_W-1:0];
            abrc_pkg::CSR_ALARM_MINUTES:
               alarm_minutes_ff <= csr_write_data[abrc_pkg::MINUTE_W-1:0];
            default: ;
         endcase
      end
   end

   // next state for the word in the input register
   always_comb begin
      logic [abrc_pkg::TIME_W-1:0] held;
      logic [abrc_pkg::TIME_W-1:0] since;

      armed_in        = armed_ff;
      active_in       = active_ff;
      beep_on_in      = beep_on_ff;
      ramp_duty_in    = ramp_duty_ff;
      ramps_left_in   = ramps_left_ff;
      toggle_start_in = toggle_start_ff;
      switch_held_in  = switch_held_ff;
      switch_start_in = switch_start_ff;
      loaded_duty_in  = loaded_duty_ff;
      held            = item.now_millis - switch_start_ff;
      since           = item.now_millis - toggle_start_ff;

      if (item.opcode == abrc_pkg::OP_SET_ENABLE) begin
         armed_in = item.enable_value;
      end else if (active_ff) begin
         armed_in = 1'b0;
         // off switch handling
         if (switch_held_ff) begin
            if (held > abrc_pkg::OFF_HOLD_MS) begin
               active_in = 1'b0;
            end else if (held > abrc_pkg::RESTART_HOLD_MS) begin
               switch_held_in = item.switch_pressed;
               if (!item.switch_pressed) begin
                  // released after the restart hold: beep from the start
                  ramp_duty_in    = abrc_pkg::DUTY_FIRST;
                  ramps_left_in   = abrc_pkg::RAMP_COUNT;
                  toggle_start_in = item.now_millis;
                  beep_on_in      = 1'b1;
                  loaded_duty_in  = abrc_pkg::DUTY_FIRST;
                  since           = '0;
               end
            end
         end else if (item.switch_pressed) begin
            switch_held_in  = 1'b1;
            switch_start_in = item.now_millis;
         end

         // buzzer toggle and ramp
         if (switch_held_in || !active_in) begin
            loaded_duty_in = '0;
         end else if (since >= abrc_pkg::HALF_PERIOD_MS) begin
            beep_on_in = ~beep_on_in;
            if (beep_on_in) begin
               ramp_duty_in = ramp_duty_in + abrc_pkg::DUTY_STEP;
               if (ramp_duty_in >= abrc_pkg::DUTY_LIMIT) begin
                  ramp_duty_in  = abrc_pkg::DUTY_FIRST;
                  ramps_left_in = ramps_left_in - abrc_pkg::RAMPS_W'(1);
                  if (ramps_left_in == '0) begin
                     active_in = 1'b0;
                  end
               end
            end
            loaded_duty_in  = (active_in && beep_on_in) ? ramp_duty_in : '0;
            toggle_start_in = toggle_start_in + abrc_pkg::HALF_PERIOD_MS;
         end
      end else if (armed_ff) begin
         // trigger on matching clock time
         if (item.rtc_hours == alarm_hours_ff && item.rtc_minutes == alarm_minutes_ff) begin
            active_in       = 1'b1;
            ramp_duty_in    = abrc_pkg::DUTY_FIRST;
            ramps_left_in   = abrc_pkg::RAMP_COUNT;
            toggle_start_in = item.now_millis;
            beep_on_in      = 1'b1;
            switch_held_in  = 1'b0;
            loaded_duty_in  = abrc_pkg::DUTY_FIRST;
         end
      end
   end

   // result reflects the state after this word
   assign result.pwm_duty     = loaded_duty_in;
   assign result.alarm_active = active_in;
   assign result.alarm_armed  = armed_in;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff        <= 1'b0;
         active_ff       <= 1'b0;
         beep_on_ff      <= 1'b0;
         ramp_duty_ff    <= '0;
         ramps_left_ff   <= '0;
         toggle_start_ff <= '0;
         switch_held_ff  <= 1'b0;
         switch_start_ff <= '0;
         loaded_duty_ff  <= '0;
      end else if (fire) begin
         armed_ff        <= armed_in;
         active_ff       <= active_in;
         beep_on_ff      <= beep_on_in;
         ramp_duty_ff    <= ramp_duty_in;
         ramps_left_ff   <= ramps_left_in;
         toggle_start_ff <= toggle_start_in;
         switch_held_ff  <= switch_held_in;
         switch_start_ff <= switch_start_in;
         loaded_duty_ff  <= loaded_duty_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/alarm_buzzer_ramp_controller.sv -----
// alarm_buzzer_ramp_controller: top level, input register, alarm core and
// result register. Depends on abrc_pkg, abrc_in_stage and abrc_core.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   req      | req_valid / req_stall  | opcode, now_millis, switch, rtc time, enable
//   rsp      | rsp_valid / rsp_stall  | pwm_duty, alarm_active, alarm_armed
//   csr      | csr_write_enable       | csr_index, csr_write_data
//
// one word per cycle while rsp is not stalled; each result reaches rsp through the
// input register, then the state update feeding the result register
// a stalled result register holds the input register, which then stalls req
// synchronous reset clears state, flags and loads the default alarm time 10:00
`default_nettype none

module alarm_buzzer_ramp_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_opcode,
   input  wire logic [abrc_pkg::TIME_W-1:0]         req_now_millis,
   input  wire logic                                req_switch_pressed,
   input  wire logic [abrc_pkg::HOUR_W-1:0]         req_rtc_hours,
   input  wire logic [abrc_pkg::MINUTE_W-1:0]       req_rtc_minutes,
   input  wire logic                                req_enable_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [abrc_pkg::DUTY_W-1:0]              rsp_pwm_duty,
   output logic                                     rsp_alarm_active,
   output logic                                     rsp_alarm_armed,
   input  wire logic                                csr_write_enable,
   input  wire logic [abrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [abrc_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   abrc_pkg::req_item_type req_item;
   abrc_pkg::req_item_type stage_item;
   abrc_pkg::rsp_item_type core_result;
   abrc_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic                   stage_valid;
   logic                   advance;
   logic                   rsp_valid_ff, rsp_valid_in;

   // pack request word
   assign req_item.opcode         = req_opcode;
   assign req_item.now_millis     = req_now_millis;
   assign req_item.switch_pressed = req_switch_pressed;
   assign req_item.rtc_hours      = req_rtc_hours;
   assign req_item.rtc_minutes    = req_rtc_minutes;
   assign req_item.enable_value   = req_enable_value;

   // word moves on when the result register is free or being drained
   assign advance = stage_valid & (~rsp_valid_ff | ~rsp_stall);

   abrc_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_item  (req_item),
      .in_stall (req_stall),
      .take     (advance),
      .valid_ff (stage_valid),
      .item_ff  (stage_item)
   );

   abrc_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fire             (advance),
      .item             (stage_item),
      .result           (core_result)
   );

   // result register
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);
   assign rsp_item_in  = advance ? core_result : rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pwm_duty     = rsp_item_ff.pwm_duty;
   assign rsp_alarm_active = rsp_item_ff.alarm_active;
   assign rsp_alarm_armed  = rsp_item_ff.alarm_armed;

   // a loaded duty means the alarm is sounding
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pwm_duty != '0) |-> rsp_alarm_active)
      else $error("nonzero duty while alarm inactive");

   // loaded duty stays on the ramp
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pwm_duty != '0) |->
      (rsp_pwm_duty >= abrc_pkg::DUTY_FIRST && rsp_pwm_duty < abrc_pkg::DUTY_LIMIT))
      else $error("duty outside ramp range");

   // a word that moves on shows up as a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced word lost");

endmodule

`default_nettype wire

// ----- test/abrc_checker.sv -----
// abrc_checker: watches the req, rsp and csr ports of the alarm buzzer ramp
// controller, predicts every result word and compares it with what comes out.
// Depends on abrc_pkg for field widths, codes and timing constants.

module abrc_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [abrc_pkg::TIME_W-1:0]         req_now_millis,
   input  logic                                req_switch_pressed,
   input  logic [abrc_pkg::HOUR_W-1:0]         req_rtc_hours,
   input  logic [abrc_pkg::MINUTE_W-1:0]       req_rtc_minutes,
   input  logic                                req_enable_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [abrc_pkg::DUTY_W-1:0]         rsp_pwm_duty,
   input  logic                                rsp_alarm_active,
   input  logic                                rsp_alarm_armed,
   input  logic                                csr_write_enable,
   input  logic [abrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [abrc_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output int                                  failures,
   output int                                  outstanding
);

   import abrc_pkg::*;

   // alarm time copy
   logic [HOUR_W-1:0]   set_hours;
   logic [MINUTE_W-1:0] set_minutes;

   // predicted alarm state
   logic                is_armed;
   logic                is_sounding;
   logic                tone_on;
   logic [DUTY_W-1:0]   duty_ramp;
   logic [RAMPS_W-1:0]  ramps_remaining;
   logic [TIME_W-1:0]   phase_start;
   logic                off_held;
   logic [TIME_W-1:0]   off_start;
   logic [DUTY_W-1:0]   duty_out;

   // status words still owed by the block, oldest first
   rsp_item_type        awaited_status[$];
   req_item_type        taken_word;
   rsp_item_type        predicted;
   rsp_item_type        want;
   rsp_item_type        got;
   int                  mismatches = 0;

   // start a fresh ramp with the buzzer on
   task automatic restart_tone(input logic [TIME_W-1:0] now);
      duty_ramp       = DUTY_FIRST;
      ramps_remaining = RAMP_COUNT;
      phase_start     = now;
      tone_on         = 1'b1;
      off_held        = 1'b0;
      duty_out        = DUTY_FIRST;
   endtask

   // one input word in, the status word it produces out
   task automatic advance_alarm(input req_item_type w, output rsp_item_type r);
      logic [TIME_W-1:0] held;
      logic [TIME_W-1:0] since;
      if (w.opcode == OP_SET_ENABLE) begin
         is_armed = w.enable_value;
      end else if (is_sounding) begin
         is_armed = 1'b0;
         // off switch: mute while held, end after 8 s, restart after 1 s
         if (off_held) begin
            held = w.now_millis - off_start;
            if (held > OFF_HOLD_MS) begin
               is_sounding = 1'b0;
            end else if (held > RESTART_HOLD_MS) begin
               off_held = w.switch_pressed;
               if (!off_held) restart_tone(w.now_millis);
            end
         end else if (w.switch_pressed) begin
            off_held  = 1'b1;
            off_start = w.now_millis;
         end
         // half-period toggle and duty ramp
         if (off_held || !is_sounding) begin
            duty_out = '0;
         end else begin
            since = w.now_millis - phase_start;
            if (since >= HALF_PERIOD_MS) begin
               tone_on = !tone_on;
               if (tone_on) begin
                  duty_ramp = duty_ramp + DUTY_STEP;
                  if (duty_ramp >= DUTY_LIMIT) begin
                     duty_ramp       = DUTY_FIRST;
                     ramps_remaining = ramps_remaining - RAMPS_W'(1);
                     if (ramps_remaining == '0) is_sounding = 1'b0;
                  end
               end
               duty_out    = (is_sounding && tone_on) ? duty_ramp : '0;
               phase_start = phase_start + HALF_PERIOD_MS;
            end
         end
      end else if (is_armed) begin
         // trigger on an exact hour and minute match
         if (w.rtc_hours == set_hours && w.rtc_minutes == set_minutes) begin
            is_sounding = 1'b1;
            restart_tone(w.now_millis);
         end
      end
      r.pwm_duty     = duty_out;
      r.alarm_active = is_sounding;
      r.alarm_armed  = is_armed;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         set_hours       = ALARM_HOURS_RESET;
         set_minutes     = ALARM_MINUTES_RESET;
         is_armed        = 1'b0;
         is_sounding     = 1'b0;
         tone_on         = 1'b0;
         duty_ramp       = '0;
         ramps_remaining = '0;
         phase_start     = '0;
         off_held        = 1'b0;
         off_start       = '0;
         duty_out        = '0;
         awaited_status.delete();
      end else begin
         // result word against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got.pwm_duty     = rsp_pwm_duty;
            got.alarm_active = rsp_alarm_active;
            got.alarm_armed  = rsp_alarm_armed;
            if (awaited_status.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word: duty %h active %b armed %b",
                        $time, got.pwm_duty, got.alarm_active, got.alarm_armed);
            end else begin
               want = awaited_status.pop_front();
               if (got.pwm_duty !== want.pwm_duty || got.alarm_active !== want.alarm_active
                   || got.alarm_armed !== want.alarm_armed) begin
                  mismatches++;
                  $display("%0t: expected duty %h active %b armed %b, actual duty %h active %b armed %b",
                           $time, want.pwm_duty, want.alarm_active, want.alarm_armed,
                           got.pwm_duty, got.alarm_active, got.alarm_armed);
               end
            end
         end
         // input word accepted
         if (req_valid && !req_stall) begin
            taken_word.opcode         = req_opcode;
            taken_word.now_millis     = req_now_millis;
            taken_word.switch_pressed = req_switch_pressed;
            taken_word.rtc_hours      = req_rtc_hours;
            taken_word.rtc_minutes    = req_rtc_minutes;
            taken_word.enable_value   = req_enable_value;
            advance_alarm(taken_word, predicted);
            awaited_status.push_back(predicted);
         end
         // alarm time writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ALARM_HOURS:   set_hours   = csr_write_data[HOUR_W-1:0];
               CSR_ALARM_MINUTES: set_minutes = csr_write_data[MINUTE_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding = awaited_status.size();
      failures    = mismatches + outstanding;
   end

endmodule

// ----- test/tb_alarm_buzzer_ramp_controller.sv -----
// tb_alarm_buzzer_ramp_controller: drives directed and random words and alarm
// time writes into the controller and reports the verdict.
// Depends on abrc_pkg, alarm_buzzer_ramp_controller and abrc_checker.

module tb_alarm_buzzer_ramp_controller;

   import abrc_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_WORDS  = 170;
   localparam int SOAK_TICKS   = 600;

   logic                  clock;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_stall;
   logic                  req_opcode         = OP_TICK;
   logic [TIME_W-1:0]     req_now_millis     = '0;
   logic                  req_switch_pressed = 1'b0;
   logic [HOUR_W-1:0]     req_rtc_hours      = '0;
   logic [MINUTE_W-1:0]   req_rtc_minutes    = '0;
   logic                  req_enable_value   = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall          = 1'b0;
   logic [DUTY_W-1:0]     rsp_pwm_duty;
   logic                  rsp_alarm_active;
   logic                  rsp_alarm_armed;
   logic                  csr_write_enable   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index          = CSR_ALARM_HOURS;
   logic [CSR_DATA_W-1:0] csr_write_data     = '0;

   int                    failures;
   int                    outstanding;
   int                    words_sent   = 0;
   int                    quiet_cycles = 0;
   logic                  steady       = 1'b0;
   logic [TIME_W-1:0]     now_ms       = '0;
   logic [HOUR_W-1:0]     alarm_hh     = ALARM_HOURS_RESET;
   logic [MINUTE_W-1:0]   alarm_mm     = ALARM_MINUTES_RESET;

   alarm_buzzer_ramp_controller u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_now_millis     (req_now_millis),
      .req_switch_pressed (req_switch_pressed),
      .req_rtc_hours      (req_rtc_hours),
      .req_rtc_minutes    (req_rtc_minutes),
      .req_enable_value   (req_enable_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pwm_duty       (rsp_pwm_duty),
      .rsp_alarm_active   (rsp_alarm_active),
      .rsp_alarm_armed    (rsp_alarm_armed),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   abrc_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_now_millis     (req_now_millis),
      .req_switch_pressed (req_switch_pressed),
      .req_rtc_hours      (req_rtc_hours),
      .req_rtc_minutes    (req_rtc_minutes),
      .req_enable_value   (req_enable_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pwm_duty       (rsp_pwm_duty),
      .rsp_alarm_active   (rsp_alarm_active),
      .rsp_alarm_armed    (rsp_alarm_armed),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .failures           (failures),
      .outstanding        (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side stalls at random except during steady stretches
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 11);
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one word, with random idle cycles first, and wait for its accept
   task automatic send_word(input logic op, input logic [TIME_W-1:0] now, input logic sw,
                            input logic [HOUR_W-1:0] hh, input logic [MINUTE_W-1:0] mm,
                            input logic en);
      while (!steady && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_now_millis     <= now;
      req_switch_pressed <= sw;
      req_rtc_hours      <= hh;
      req_rtc_minutes    <= mm;
      req_enable_value   <= en;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // stop offering words and let every owed status word come out
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // both alarm time registers, back to back
   task automatic set_alarm_time(input logic [HOUR_W-1:0] hh, input logic [MINUTE_W-1:0] mm);
      alarm_hh         = hh;
      alarm_mm         = mm;
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ALARM_HOURS;
      csr_write_data   <= CSR_DATA_W'(hh);
      @(posedge clock);
      csr_index        <= CSR_ALARM_MINUTES;
      csr_write_data   <= mm;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // tick spacing: mostly short, some exact half periods, zeros and big jumps
   function automatic logic [TIME_W-1:0] pick_step();
      int r;
      r = $urandom_range(99);
      if (r < 10) return HALF_PERIOD_MS;
      else if (r < 14) return TIME_W'($urandom);
      else if (r < 18) return '0;
      else return TIME_W'($urandom_range(1, 350));
   endfunction

   // arm, miss a few times, trigger, then run the alarm with switch activity;
   // a soak run uses every tick to toggle through one full ramp wrap
   task automatic run_episode(input int ticks, input logic soak);
      logic              pressing;
      logic [TIME_W-1:0] press_from;
      logic [TIME_W-1:0] press_for;
      int                n;
      pressing   = 1'b0;
      press_from = '0;
      press_for  = '0;
      steady     = soak;
      send_word(OP_SET_ENABLE, TIME_W'($urandom), 1'($urandom), HOUR_W'($urandom),
                MINUTE_W'($urandom), 1'b1);
      repeat ($urandom_range(3)) begin
         now_ms += pick_step();
         send_word(OP_TICK, now_ms, 1'($urandom), HOUR_W'($urandom), MINUTE_W'($urandom),
                   1'($urandom));
      end
      now_ms += pick_step();
      send_word(OP_TICK, now_ms, 1'($urandom), alarm_hh, alarm_mm, 1'($urandom));
      for (n = 0; n < ticks; n++) begin
         if (soak) now_ms += TIME_W'($urandom_range(300, 420));
         else now_ms += pick_step();
         // off switch presses of short, restart and off lengths
         if (!soak && !pressing && $urandom_range(99) < 4) begin
            pressing   = 1'b1;
            press_from = now_ms;
            case ($urandom_range(2))
               0: press_for = TIME_W'($urandom_range(50, 1000));
               1: press_for = TIME_W'($urandom_range(1001, 8000));
               default: press_for = TIME_W'($urandom_range(8001, 12000));
            endcase
         end else if (pressing && TIME_W'(now_ms - press_from) >= press_for) begin
            pressing = 1'b0;
         end
         if (!soak && $urandom_range(99) < 2)
            send_word(OP_SET_ENABLE, TIME_W'($urandom), 1'($urandom), HOUR_W'($urandom),
                      MINUTE_W'($urandom), 1'($urandom));
         else
            send_word(OP_TICK, now_ms, pressing, HOUR_W'($urandom), MINUTE_W'($urandom),
                      1'($urandom));
      end
      steady = 1'b0;
   endtask

   initial begin
      int p;
      int stop_at;
      logic [HOUR_W-1:0]   hh_list [6];
      logic [MINUTE_W-1:0] mm_list [6];

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: unarmed ticks, arm, out-of-range clock, trigger across timer wrap
      send_word(OP_TICK, 16'd0, 1'b0, 5'd0, 6'd0, 1'b0);
      send_word(OP_TICK, 16'd100, 1'b0, ALARM_HOURS_RESET, ALARM_MINUTES_RESET, 1'b1);
      send_word(OP_SET_ENABLE, 16'hFFFF, 1'b1, 5'd31, 6'd63, 1'b1);
      send_word(OP_TICK, 16'd65000, 1'b1, 5'd31, 6'd63, 1'b0);
      send_word(OP_TICK, 16'd65100, 1'b0, ALARM_HOURS_RESET, 6'd1, 1'b0);
      send_word(OP_TICK, 16'd65400, 1'b0, ALARM_HOURS_RESET, ALARM_MINUTES_RESET, 1'b0);
      // re-arm while sounding, then the next tick clears it
      send_word(OP_SET_ENABLE, 16'd0, 1'b0, 5'd0, 6'd0, 1'b1);
      // one short of a half period, exactly one, then the first on-phase step
      send_word(OP_TICK, 16'd163, 1'b0, 5'd0, 6'd0, 1'b0);
      send_word(OP_TICK, 16'd164, 1'b0, 5'd0, 6'd0, 1'b0);
      send_word(OP_TICK, 16'd464, 1'b0, 5'd0, 6'd0, 1'b0);
      // switch held exactly 1 s, then just past it after release: restart
      send_word(OP_TICK, 16'd500, 1'b1, 5'd0, 6'd0, 1'b0);
      send_word(OP_TICK, 16'd1500, 1'b0, 5'd0, 6'd0, 1'b0);
      send_word(OP_TICK, 16'd1501, 1'b0, 5'd0, 6'd0, 1'b0);
      // switch held exactly 8 s, then just past it: alarm ends
      send_word(OP_TICK, 16'd1600, 1'b1, 5'd0, 6'd0, 1'b0);
      send_word(OP_TICK, 16'd9600, 1'b1, 5'd0, 6'd0, 1'b0);
      send_word(OP_TICK, 16'd9601, 1'b1, 5'd0, 6'd0, 1'b0);
      send_word(OP_TICK, 16'd9700, 1'b0, ALARM_HOURS_RESET, ALARM_MINUTES_RESET, 1'b0);
      // trigger again, disarm while sounding, toggle on a wrapped difference
      send_word(OP_SET_ENABLE, 16'd0, 1'b0, 5'd0, 6'd0, 1'b1);
      send_word(OP_TICK, 16'd9800, 1'b0, ALARM_HOURS_RESET, ALARM_MINUTES_RESET, 1'b0);
      send_word(OP_SET_ENABLE, 16'd0, 1'b0, 5'd0, 6'd0, 1'b0);
      send_word(OP_TICK, 16'd9799, 1'b0, 5'd0, 6'd0, 1'b0);
      send_word(OP_TICK, 16'd10400, 1'b0, 5'd0, 6'd0, 1'b0);
      // one long press skipping straight past 8 s
      send_word(OP_TICK, 16'd10500, 1'b1, 5'd0, 6'd0, 1'b0);
      send_word(OP_TICK, 16'd19500, 1'b0, 5'd0, 6'd0, 1'b0);
      now_ms = 16'd19500;

      // random phases, each with its own alarm time, the extremes first
      hh_list = '{5'd0, 5'd23, 5'd0, 5'd23, HOUR_W'($urandom_range(23)),
                  HOUR_W'($urandom_range(23))};
      mm_list = '{6'd0, 6'd59, 6'd59, 6'd0, MINUTE_W'($urandom_range(59)),
                  MINUTE_W'($urandom_range(59))};
      for (p = 0; p < 6; p++) begin
         wait_quiet();
         set_alarm_time(hh_list[p], mm_list[p]);
         // one alarm left to run through a full ramp wrap, no idling at all
         if (p == 1) run_episode(SOAK_TICKS, 1'b1);
         stop_at = words_sent + PHASE_WORDS;
         while (words_sent < stop_at) begin
            if ($urandom_range(99) < 70) begin
               run_episode($urandom_range(20, 150), 1'b0);
            end else begin
               // noise: any opcode, any field values, now and then the alarm time
               repeat ($urandom_range(5, 30)) begin
                  now_ms += pick_step();
                  if ($urandom_range(99) < 10)
                     send_word(1'($urandom), now_ms, 1'($urandom), alarm_hh, alarm_mm,
                               1'($urandom));
                  else
                     send_word(1'($urandom), now_ms, 1'($urandom), HOUR_W'($urandom),
                               MINUTE_W'($urandom), 1'($urandom));
               end
            end
         end
      end

      wait_quiet();
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/abrc_pkg.sv
src/abrc_in_stage.sv
src/abrc_core.sv
src/alarm_buzzer_ramp_controller.sv
test/abrc_checker.sv
test/tb_alarm_buzzer_ramp_controller.sv
